[hw/rtl/fdm_pkg.sv]
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared types and constants for the follow drive mixer.
// ----------------------------------------------------------------------------
package fdm_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_SPEED_UP = 2'd1,
    KIND_SPEED_DN = 2'd2,
    KIND_TAG      = 2'd3
  } kind_t;

  // register index (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_FOLLOW_DIST = 2'd0,
    REG_STEER_GAIN  = 2'd1,
    REG_START_SPEED = 2'd2,
    REG_TIMEOUT     = 2'd3
  } reg_idx_t;

  localparam int unsigned SPEED_W = 13;
  localparam int unsigned PWM_W   = 24;
  localparam int unsigned AZ_W    = 16;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [SPEED_W-1:0] SPEED_MAX  = 13'd7200;
  localparam logic [SPEED_W-1:0] SPEED_MIN  = 13'd4500;
  localparam logic [SPEED_W-1:0] SPEED_STEP = 13'd1000;
  // thresholds beyond which a key step hits the clamp
  localparam logic [SPEED_W-1:0] SPEED_UP_LIM = SPEED_MAX - SPEED_STEP;
  localparam logic [SPEED_W-1:0] SPEED_DN_LIM = SPEED_MIN + SPEED_STEP;

  localparam logic [TICK_W-1:0]  TICK_MAX = '1;

  localparam logic [DIST_W-1:0]  FOLLOW_DIST_RST = 32'd100;
  localparam logic [GAIN_W-1:0]  STEER_GAIN_RST  = 8'd10;
  localparam logic [SPEED_W-1:0] START_SPEED_RST = 13'd4500;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST     = 16'd200;

endpackage

[hw/rtl/follow_drive_mixer.sv]
// ----------------------------------------------------------------------------
// follow_drive_mixer
// Open-loop differential steering mixer for a tag-following cart.
// ----------------------------------------------------------------------------
// Flow: a request accepted at a clock edge updates the tracking state there;
//   its result is then registered and shown on the out_ ports.
// Throughput: one request per cycle while out_stall is low; the state update
//   and the mixer (16x8 multiply, subtract) each fit one register stage.
// Reset (rst_n low at a clock edge): registers take their default values,
//   base speed is 4500, distance, azimuth and tick count are zero, and
//   both pipeline stages are empty.
module follow_drive_mixer
  import fdm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [DIST_W-1:0]        in_tag_distance,
  input  logic signed [AZ_W-1:0]   in_tag_azimuth,

  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PWM_W-1:0]  out_pwm_left,
  output logic signed [PWM_W-1:0]  out_pwm_right,
  output logic                     out_drive_enable,
  output logic [SPEED_W-1:0]       out_speed_now,

  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]  follow_dist_r;
  logic [GAIN_W-1:0]  steer_gain_r;
  logic [SPEED_W-1:0] start_speed_r;
  logic [TICK_W-1:0]  timeout_r;

  // Tracking state. It doubles as the first pipeline stage: a request's
  // result depends only on the state after it, so stage 1 is just a valid
  // flag on top of these registers.
  logic [SPEED_W-1:0] base_speed_r, base_speed_nxt;
  logic [DIST_W-1:0]  dist_r,       dist_nxt;
  logic [AZ_W-1:0]    az_r,         az_nxt;
  logic [TICK_W-1:0]  ticks_r,      ticks_nxt;
  logic               s1_valid_r,   s1_valid_nxt;

  // result register
  logic               out_valid_r,  out_valid_nxt;
  logic [PWM_W-1:0]   pwm_left_r,   pwm_left_nxt;
  logic [PWM_W-1:0]   pwm_right_r,  pwm_right_nxt;
  logic               drive_en_r,   drive_en_nxt;
  logic [SPEED_W-1:0] speed_now_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     in_acc;
  logic     out_load;
  kind_t    kind;
  logic [DIST_W-1:0]  dist_upd;
  logic [TICK_W-1:0]  ticks_upd;
  logic [AZ_W-1:0]    mag;
  logic [PWM_W-1:0]   cut;
  logic [PWM_W-1:0]   base_ext;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_FOLLOW_DIST: prdata = follow_dist_r;
      REG_STEER_GAIN:  prdata = {24'd0, steer_gain_r};
      REG_START_SPEED: prdata = {19'd0, start_speed_r};
      REG_TIMEOUT:     prdata = {16'd0, timeout_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 hands off when the result register is empty or being
  // drained; a new request is taken whenever stage 1 empties or is empty.
  // ---------------------------------------------------------------------------
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  // ---------------------------------------------------------------------------
  // State update for an accepted request
  // ---------------------------------------------------------------------------
  assign kind = kind_t'(in_kind);

  always_comb begin
    base_speed_nxt = base_speed_r;
    dist_upd       = dist_r;
    az_nxt         = az_r;
    ticks_upd      = ticks_r;
    unique case (kind)
      KIND_TICK: begin
        if (ticks_r != TICK_MAX) ticks_upd = ticks_r + 16'd1;
      end
      KIND_SPEED_UP: begin
        // a preset above the top speed also lands on the clamp
        base_speed_nxt = (base_speed_r > SPEED_UP_LIM) ? SPEED_MAX
                                                       : base_speed_r + SPEED_STEP;
      end
      KIND_SPEED_DN: begin
        base_speed_nxt = (base_speed_r < SPEED_DN_LIM) ? SPEED_MIN
                                                       : base_speed_r - SPEED_STEP;
      end
      KIND_TAG: begin
        dist_upd  = in_tag_distance;
        az_nxt    = in_tag_azimuth;
        ticks_upd = '0;
      end
      default: ;
    endcase
    ticks_nxt = ticks_upd;
    // stale tag: drop the distance, keep the bearing
    dist_nxt  = (ticks_upd > timeout_r) ? '0 : dist_upd;
  end

  // ---------------------------------------------------------------------------
  // Mixer: slow the side the tag lies toward by |azimuth| * gain
  // ---------------------------------------------------------------------------
  always_comb begin
    mag      = az_r[AZ_W-1] ? (~az_r + 16'd1) : az_r;   // 32768 fits unsigned
    cut      = {8'd0, mag} * {16'd0, steer_gain_r};
    base_ext = {11'd0, base_speed_r};
    if (az_r[AZ_W-1]) begin
      pwm_left_nxt  = base_ext - cut;
      pwm_right_nxt = base_ext;
    end else begin
      pwm_left_nxt  = base_ext;
      pwm_right_nxt = base_ext - cut;
    end
    drive_en_nxt = dist_r > follow_dist_r;
  end

  // ---------------------------------------------------------------------------
  // Clocked
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      follow_dist_r <= FOLLOW_DIST_RST;
      steer_gain_r  <= STEER_GAIN_RST;
      start_speed_r <= START_SPEED_RST;
      timeout_r     <= TIMEOUT_RST;
      base_speed_r  <= START_SPEED_RST;
      dist_r        <= '0;
      az_r          <= '0;
      ticks_r       <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        base_speed_r <= base_speed_nxt;
        dist_r       <= dist_nxt;
        az_r         <= az_nxt;
        ticks_r      <= ticks_nxt;
      end
      // register writes must arrive only while idle; the block does not check
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FOLLOW_DIST: follow_dist_r <= pwdata;
          REG_STEER_GAIN:  steer_gain_r  <= pwdata[GAIN_W-1:0];
          REG_START_SPEED: begin
            start_speed_r <= pwdata[SPEED_W-1:0];
            base_speed_r  <= pwdata[SPEED_W-1:0];
          end
          REG_TIMEOUT:     timeout_r     <= pwdata[TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      pwm_left_r  <= pwm_left_nxt;
      pwm_right_r <= pwm_right_nxt;
      drive_en_r  <= drive_en_nxt;
      speed_now_r <= base_speed_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pwm_left     = pwm_left_r;
  assign out_pwm_right    = pwm_right_r;
  assign out_drive_enable = drive_en_r;
  assign out_speed_now    = speed_now_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("request stalled with room in the pipeline");

  a_tag_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_TAG) |=> (ticks_r == '0))
    else $error("tag report did not restart the timeout");

  a_speed_up_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_SPEED_UP && !cfg_wr) |=> (base_speed_r <= SPEED_MAX))
    else $error("speed-up went past the top speed");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for follow_drive_mixer. A queue-fed driver offers
// requests, a monitor checks every result against a cycle-free model of the
// mixer, and APB writes change the registers between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fdm_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int LONG_HOLD       = 50;
  localparam int SAT_TICKS       = 20;     // runs past the lowered timeout below
  localparam int END_WAIT        = 4;

  // signed copies of the package limits, so the speed math stays signed
  localparam int SPD_MAX  = SPEED_MAX;
  localparam int SPD_MIN  = SPEED_MIN;
  localparam int SPD_STEP = SPEED_STEP;

  typedef struct packed {
    kind_t                  kind;
    logic [DIST_W-1:0]      tag_dist;
    logic signed [AZ_W-1:0] az;
  } fdm_req_t;

  typedef struct packed {
    logic signed [PWM_W-1:0] pwm_left;
    logic signed [PWM_W-1:0] pwm_right;
    logic                    drive_en;
    logic [SPEED_W-1:0]      speed;
  } mix_result_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_kind = KIND_TICK;
  logic [DIST_W-1:0]       in_tag_distance = '0;
  logic signed [AZ_W-1:0]  in_tag_azimuth = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [PWM_W-1:0] out_pwm_left;
  logic signed [PWM_W-1:0] out_pwm_right;
  logic                    out_drive_enable;
  logic [SPEED_W-1:0]      out_speed_now;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  follow_drive_mixer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_tag_distance  (in_tag_distance),
    .in_tag_azimuth   (in_tag_azimuth),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pwm_left     (out_pwm_left),
    .out_pwm_right    (out_pwm_right),
    .out_drive_enable (out_drive_enable),
    .out_speed_now    (out_speed_now),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Mixer model: registers and state; the base speed is a signed int, the rest at the block's widths
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0]      follow_q  = FOLLOW_DIST_RST;
  logic [GAIN_W-1:0]      gain_q    = STEER_GAIN_RST;
  logic [SPEED_W-1:0]     start_q   = START_SPEED_RST;
  logic [TICK_W-1:0]      timeout_q = TIMEOUT_RST;

  int                     base_spd  = START_SPEED_RST;
  logic [DIST_W-1:0]      dist_q    = '0;
  logic signed [AZ_W-1:0] az_q      = '0;
  logic [TICK_W-1:0]      tick_cnt  = '0;

  fdm_req_t    pending_reqs[$];   // requests not yet offered to the block
  mix_result_t expected_mix[$];   // predicted results, oldest first

  int  fail_cnt    = 0;
  int  cycle_cnt   = 0;
  bit  quiet       = 1'b0;        // no idling on either side
  bit  feed_hold   = 1'b0;        // driver stops offering new requests
  int  long_asked  = 0;
  int  long_served = 0;

  // Advance the model by one request and return the result it produces.
  function automatic mix_result_t mix_predict(input fdm_req_t req);
    mix_result_t r;
    int mag;
    int cut;
    int pl;
    int pr;
    case (req.kind)
      KIND_TICK: begin
        if (tick_cnt != TICK_MAX) tick_cnt++;
      end
      KIND_SPEED_UP: begin
        base_spd = base_spd + SPD_STEP;
        if (base_spd > SPD_MAX) base_spd = SPD_MAX;
      end
      KIND_SPEED_DN: begin
        // signed: a low or zero preset lands on the floor, no wrap
        base_spd = base_spd - SPD_STEP;
        if (base_spd < SPD_MIN) base_spd = SPD_MIN;
      end
      default: begin
        dist_q   = req.tag_dist;
        az_q     = req.az;
        tick_cnt = '0;
      end
    endcase
    // timeout is checked after every request, not only after ticks
    if (tick_cnt > timeout_q) dist_q = '0;

    mag = (az_q < 0) ? -int'(az_q) : int'(az_q);
    cut = mag * int'(gain_q);
    if (az_q < 0) begin
      pl = base_spd - cut;
      pr = base_spd;
    end else begin
      pl = base_spd;
      pr = base_spd - cut;
    end
    r.pwm_left  = pl[PWM_W-1:0];
    r.pwm_right = pr[PWM_W-1:0];
    r.drive_en  = dist_q > follow_q;
    r.speed     = base_spd[SPEED_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued requests, random gaps after some of them
  // --------------------------------------------------------------------------
  fdm_req_t drv_req;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) expected_mix.push_back(mix_predict(drv_req));
      // a stalled request holds its payload
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!feed_hold && pending_reqs.size() > 0) begin
          drv_req = pending_reqs.pop_front();
          in_kind         <= drv_req.kind;
          in_tag_distance <= drv_req.tag_dist;
          in_tag_azimuth  <= drv_req.az;
          in_valid        <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side stall: random bursts, plus long holds that fill the block
  // --------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_served != long_asked) begin
      long_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(input string field, input longint want,
                                      input longint got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    mix_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_mix.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result, expected none, actual L=%0d R=%0d en=%0d spd=%0d",
                 $time, out_pwm_left, out_pwm_right, out_drive_enable, out_speed_now);
      end else begin
        want = expected_mix.pop_front();
        check_field("pwm_left", want.pwm_left, out_pwm_left);
        check_field("pwm_right", want.pwm_right, out_pwm_right);
        check_field("drive_enable", want.drive_en, out_drive_enable);
        check_field("speed_now", want.speed, out_speed_now);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_mix.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(input kind_t kind, input logic [DIST_W-1:0] tag_dist,
                          input logic signed [AZ_W-1:0] az);
    fdm_req_t r;
    r.kind     = kind;
    r.tag_dist = tag_dist;
    r.az       = az;
    pending_reqs.push_back(r);
  endtask

  // APB write: setup, access, done at the edge with penable and pready high.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FOLLOW_DIST: follow_q = value;
      REG_STEER_GAIN:  gain_q = value[GAIN_W-1:0];
      REG_START_SPEED: begin
        // the preset is loaded into the base speed at once
        start_q  = value[SPEED_W-1:0];
        base_spd = start_q;
      end
      default:         timeout_q = value[TICK_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [DIST_W-1:0] fd, input logic [GAIN_W-1:0] g,
                                input logic [SPEED_W-1:0] ss, input logic [TICK_W-1:0] to);
    reg_write(REG_FOLLOW_DIST, fd);
    reg_write(REG_STEER_GAIN, g);
    reg_write(REG_START_SPEED, ss);
    reg_write(REG_TIMEOUT, to);
  endtask

  // Block is idle once nothing is queued, offered or outstanding.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_mix.size() > 0);
  endtask

  // Sender pause: stop offering until every outstanding result is back.
  task automatic pause_feed(input int left_in_queue);
    while (pending_reqs.size() > left_in_queue) @(negedge clk);
    feed_hold = 1'b1;
    while (in_valid || expected_mix.size() > 0) @(negedge clk);
    feed_hold = 1'b0;
  endtask

  // Mostly ticks and tag reports so the timeout and the threshold both matter.
  function automatic fdm_req_t random_request();
    fdm_req_t r;
    int pick;
    r.tag_dist = $urandom;
    r.az       = AZ_W'($urandom);
    pick       = $urandom_range(0, 99);
    if (pick < 40)      r.kind = KIND_TICK;
    else if (pick < 52) r.kind = KIND_SPEED_UP;
    else if (pick < 64) r.kind = KIND_SPEED_DN;
    else                r.kind = KIND_TAG;
    if (r.kind == KIND_TAG) begin
      case ($urandom_range(0, 3))
        0: r.tag_dist = follow_q + 32'($urandom_range(0, 2)) - 32'd1;  // around threshold
        1: r.tag_dist = $urandom_range(0, 400);
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: r.az = AZ_W'(int'($urandom_range(0, 100)) - 50);
        1: r.az = ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7fff;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic random_settings();
    logic [DIST_W-1:0]  fd;
    logic [GAIN_W-1:0]  g;
    logic [SPEED_W-1:0] ss;
    logic [TICK_W-1:0]  to;
    case ($urandom_range(0, 3))
      0:       fd = '0;
      1:       fd = '1;
      2:       fd = $urandom_range(0, 400);
      default: fd = $urandom;
    endcase
    g = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       ss = '0;
      1:       ss = SPEED_MAX;
      2:       ss = '1;
      3:       ss = SPEED_DN_LIM - 13'd1;
      default: ss = SPEED_W'($urandom_range(0, 8191));
    endcase
    case ($urandom_range(0, 3))
      0:       to = '0;
      1:       to = '1;
      2:       to = TIMEOUT_RST;
      default: to = TICK_W'($urandom_range(0, 30));
    endcase
    apply_settings(fd, g, ss, to);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset settings: threshold edges, steering sides, speed clamps
    push_req(KIND_TICK, 32'hFFFF_FFFF, 16'sh7fff);  // payload ignored on a tick
    push_req(KIND_TAG, 32'd101, 16'sd0);            // zero azimuth, just above threshold
    push_req(KIND_TAG, 32'd100, 16'sd0);            // at threshold: not enabled
    push_req(KIND_TAG, 32'hFFFF_FFFF, 16'sh8000);   // far left, left side negative
    push_req(KIND_TAG, 32'd5000, 16'sh7fff);        // far right
    push_req(KIND_TAG, 32'd5000, -16'sd1);
    push_req(KIND_TAG, 32'd5000, 16'sd1);
    repeat (4) push_req(KIND_SPEED_UP, 32'd0, 16'sd0);   // up to and held at max
    repeat (4) push_req(KIND_SPEED_DN, 32'd0, 16'sd0);   // down to and held at min
    wait_drained();

    // Directed, extreme settings: timeout of zero, preset above range
    apply_settings(32'd100, 8'd255, 13'h1FFF, 16'd0);
    push_req(KIND_TAG, 32'hFFFF_FFFF, 16'sh8000);   // widest negative drive
    push_req(KIND_TICK, 32'd0, 16'sd0);             // distance cleared, azimuth kept
    push_req(KIND_SPEED_UP, 32'd0, 16'sd0);         // preset above max comes down to max
    wait_drained();
    reg_write(REG_START_SPEED, 32'd0);
    push_req(KIND_SPEED_DN, 32'd0, 16'sd0);         // signed floor, no wrap
    wait_drained();
    reg_write(REG_START_SPEED, 32'd0);
    push_req(KIND_SPEED_UP, 32'd0, 16'sd0);
    wait_drained();

    // Run of ticks: with the largest timeout the distance survives
    quiet = 1'b1;
    apply_settings(32'd0, 8'd3, START_SPEED_RST, 16'hFFFF);
    push_req(KIND_TAG, 32'd1, 16'sd5);
    for (int i = 0; i < SAT_TICKS; i++) push_req(KIND_TICK, $urandom, AZ_W'($urandom));
    wait_drained();
    // lowering the timeout acts on the very next request
    reg_write(REG_TIMEOUT, 32'd10);
    push_req(KIND_SPEED_UP, 32'd0, 16'sd0);
    wait_drained();

    // Random phases, each under new settings
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 4) || (p >= PHASES - 2);
      case (p)
        0:       apply_settings(32'd0, 8'd255, SPEED_MAX, 16'd0);
        1:       apply_settings(32'hFFFF_FFFF, 8'd0, 13'd0, 16'hFFFF);
        default: random_settings();
      endcase
      // long receiver hold while requests keep coming: block must back up
      if (p == 2) long_asked++;
      repeat (ITEMS_PER_PHASE) pending_reqs.push_back(random_request());
      if (p == 3) pause_feed(ITEMS_PER_PHASE / 2);
      wait_drained();
    end

    repeat (END_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[follow_drive_mixer.f]
hw/rtl/fdm_pkg.sv
hw/rtl/follow_drive_mixer.sv
sim/testbench.sv
